### design/kstg_pkg.sv
// Shared constants, types and the sine table of the keyed tone generator.
package kstg_pkg;

	localparam int TICK_RATE     = 44100;
	localparam int TABLE_SIZE    = 256;
	localparam int FRACTION_BITS = 16;

	localparam int FREQ_W     = 11;
	localparam int VOL_W      = 7;
	localparam int SAMPLE_W   = 16;
	localparam int FREQ_MIN   = 200;
	localparam int FREQ_MAX   = 1200;
	localparam int FREQ_RESET = 700;
	localparam int VOL_MAX    = 100;
	localparam int VOL_RESET  = 50;
	localparam int AMPLITUDE  = 32767;

	// APB side: two 32-bit registers at word addresses.
	localparam int DATA_W    = 32;
	localparam int REG_IDX_W = 1;
	localparam int ADDR_W    = REG_IDX_W + 2;
	localparam logic [REG_IDX_W-1:0] REG_FREQ = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_VOL  = 1'b1;

	// Phase accumulator: table index bits above the fraction bits.
	localparam int IDX_W   = $clog2(TABLE_SIZE);
	localparam int PHASE_W = IDX_W + FRACTION_BITS;
	localparam longint unsigned MODULUS = 64'd1 << PHASE_W;
	localparam int PHASE_DEPTH = 1;
	localparam int PHASE_AW    = 1;

	// Increment = freq * MODULUS / TICK_RATE, split into a whole part and a
	// remainder part that goes through a reciprocal multiply.
	localparam longint unsigned INC_WHOLE = MODULUS / TICK_RATE;
	localparam longint unsigned INC_REM   = MODULUS % TICK_RATE;
	localparam int X_W    = $clog2(FREQ_MAX * TICK_RATE);
	localparam int RS     = X_W + 2;
	localparam longint unsigned RCP = (64'd1 << RS) / TICK_RATE;
	localparam int RCP_W  = RS - $clog2(TICK_RATE) + 1;
	localparam int RP_W   = X_W + RCP_W;
	localparam int INC_STAGES = 3;
	localparam int BUSY_W     = $clog2(INC_STAGES + 1);

	// Sample datapath widths.
	localparam int DIFF_W = SAMPLE_W + 1;
	localparam int PROD_W = DIFF_W + FRACTION_BITS + 1;
	localparam int P_W    = SAMPLE_W + FRACTION_BITS + 1;
	localparam int MAG_W  = P_W - 1;
	localparam int MV_W   = MAG_W + VOL_W;
	localparam int Y_W    = MV_W - FRACTION_BITS;
	localparam int VS     = Y_W + 2;
	localparam longint unsigned VRCP = (64'd1 << VS) / VOL_MAX;
	localparam int VRCP_W = VS - $clog2(VOL_MAX) + 1;
	localparam int VP_W   = Y_W + VRCP_W;

	// Angle of one table step in radians.
	localparam real TABLE_STEP = 2.0 * 3.14159265358979323846 / real'(TABLE_SIZE);

	typedef struct packed {
		logic [PHASE_W-1:0] inc;
		logic [VOL_W-1:0]   vol;
		logic               busy;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_MAC,
		ST_SCALE,
		ST_RECIP,
		ST_FIX
	} state_t;

	typedef logic signed [SAMPLE_W-1:0] sine_rom_t [TABLE_SIZE];

	function automatic int quarter_entry(input int k);
		real x;
		x = TABLE_STEP * real'(k);
		if (k == 0)
			return 0;
		if (k >= TABLE_SIZE / 4)
			return AMPLITUDE;
		return $rtoi(real'(AMPLITUDE) * $sin(x));
	endfunction

	// Full wave built from the first quarter so that the peaks and zero
	// crossings come out exact.
	function automatic sine_rom_t build_sine();
		sine_rom_t t;
		int q;
		int h;
		q = TABLE_SIZE / 4;
		h = TABLE_SIZE / 2;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			if (i <= q)
				t[i] = SAMPLE_W'(quarter_entry(i));
			else if (i < h)
				t[i] = SAMPLE_W'(quarter_entry(h - i));
			else if (i - h <= q)
				t[i] = SAMPLE_W'(-quarter_entry(i - h));
			else
				t[i] = SAMPLE_W'(-quarter_entry(TABLE_SIZE - i));
		end
		return t;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine();

endpackage

### design/kstg_ram.sv
// Generic single-port-write, registered-read RAM.
module kstg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

### design/kstg_regs.sv
// Register file on the APB port and the pipeline that derives the phase increment.
module kstg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [kstg_pkg::ADDR_W-1:0]    paddr,
	input  logic [kstg_pkg::DATA_W-1:0]    pwdata,
	output logic [kstg_pkg::DATA_W-1:0]    prdata,
	output logic                           pready,
	output kstg_pkg::cfg_t                 cfg
);

	logic [kstg_pkg::FREQ_W-1:0]    freq_q;
	logic [kstg_pkg::VOL_W-1:0]     vol_q;
	logic [kstg_pkg::BUSY_W-1:0]    busy_q;
	logic [kstg_pkg::REG_IDX_W-1:0] reg_idx;
	logic                           wr;
	logic                           freq_wr;
	logic [kstg_pkg::FREQ_W-1:0]    freq_in;
	logic [kstg_pkg::FREQ_W-1:0]    freq_clamp;
	logic [kstg_pkg::VOL_W-1:0]     vol_in;
	logic [kstg_pkg::VOL_W-1:0]     vol_clamp;

	logic [kstg_pkg::X_W-1:0]       x_s1;
	logic [kstg_pkg::PHASE_W-1:0]   base_s1;
	logic [kstg_pkg::X_W-1:0]       x_s2;
	logic [kstg_pkg::PHASE_W-1:0]   base_s2;
	logic [kstg_pkg::FREQ_W-1:0]    q0_s2;
	logic [kstg_pkg::PHASE_W-1:0]   inc_q;
	logic [kstg_pkg::RP_W-1:0]      rprod;
	logic [kstg_pkg::X_W-1:0]       rem;
	logic [kstg_pkg::FREQ_W-1:0]    q_fix;

	assign pready  = 1'b1;
	assign reg_idx = paddr[kstg_pkg::ADDR_W-1:2];
	assign wr      = psel && penable && pwrite;
	assign freq_wr = wr && (reg_idx == kstg_pkg::REG_FREQ);

	always_comb begin
		freq_in = pwdata[kstg_pkg::FREQ_W-1:0];
		vol_in  = pwdata[kstg_pkg::VOL_W-1:0];
		if (freq_in < kstg_pkg::FREQ_W'(kstg_pkg::FREQ_MIN))
			freq_clamp = kstg_pkg::FREQ_W'(kstg_pkg::FREQ_MIN);
		else if (freq_in > kstg_pkg::FREQ_W'(kstg_pkg::FREQ_MAX))
			freq_clamp = kstg_pkg::FREQ_W'(kstg_pkg::FREQ_MAX);
		else
			freq_clamp = freq_in;
		if (vol_in > kstg_pkg::VOL_W'(kstg_pkg::VOL_MAX))
			vol_clamp = kstg_pkg::VOL_W'(kstg_pkg::VOL_MAX);
		else
			vol_clamp = vol_in;
	end

	always_comb begin
		case (reg_idx)
			kstg_pkg::REG_FREQ: prdata = kstg_pkg::DATA_W'(freq_q);
			kstg_pkg::REG_VOL:  prdata = kstg_pkg::DATA_W'(vol_q);
			default:            prdata = '0;
		endcase
	end

	// The increment pipeline restarts after reset and after every frequency
	// write; the busy count covers its latency.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= kstg_pkg::FREQ_W'(kstg_pkg::FREQ_RESET);
			vol_q  <= kstg_pkg::VOL_W'(kstg_pkg::VOL_RESET);
			busy_q <= kstg_pkg::BUSY_W'(kstg_pkg::INC_STAGES);
		end else begin
			if (freq_wr) begin
				freq_q <= freq_clamp;
				busy_q <= kstg_pkg::BUSY_W'(kstg_pkg::INC_STAGES);
			end else if (busy_q != '0) begin
				busy_q <= busy_q - 1'b1;
			end
			if (wr && (reg_idx == kstg_pkg::REG_VOL))
				vol_q <= vol_clamp;
		end
	end

	assign rprod = kstg_pkg::RP_W'(x_s1) * kstg_pkg::RP_W'(kstg_pkg::RCP);

	always_comb begin
		rem   = x_s2 - kstg_pkg::X_W'(kstg_pkg::X_W'(q0_s2)
			* kstg_pkg::X_W'(kstg_pkg::TICK_RATE));
		q_fix = q0_s2 + kstg_pkg::FREQ_W'(rem >= kstg_pkg::X_W'(kstg_pkg::TICK_RATE));
	end

	always_ff @(posedge clk) begin
		x_s1    <= kstg_pkg::X_W'(freq_q) * kstg_pkg::X_W'(kstg_pkg::INC_REM);
		base_s1 <= kstg_pkg::PHASE_W'(freq_q) * kstg_pkg::PHASE_W'(kstg_pkg::INC_WHOLE);
		x_s2    <= x_s1;
		base_s2 <= base_s1;
		q0_s2   <= kstg_pkg::FREQ_W'(rprod >> kstg_pkg::RS);
		inc_q   <= base_s2 + kstg_pkg::PHASE_W'(q_fix);
	end

	assign cfg.inc  = inc_q;
	assign cfg.vol  = vol_q;
	assign cfg.busy = (busy_q != '0) || freq_wr;

endmodule

### design/kstg_core.sv
// Sequencer and sample datapath around the phase memory.
module kstg_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  kstg_pkg::cfg_t                cfg,
	input  logic                          take,
	input  logic                          key_on,
	output logic                          ready,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [kstg_pkg::SAMPLE_W-1:0] sample
);

	kstg_pkg::state_t state_q;
	kstg_pkg::state_t state_d;

	logic                                  out_valid_q;
	logic signed [kstg_pkg::SAMPLE_W-1:0]  sample_q;
	logic                                  out_free;
	logic                                  out_load;
	logic                                  phase_vld_q;
	logic                                  key_s1;

	logic                                  ram_we;
	logic [kstg_pkg::PHASE_W-1:0]          ram_wdata;
	logic [kstg_pkg::PHASE_W-1:0]          ram_rdata;
	logic [kstg_pkg::PHASE_AW-1:0]         ram_addr;

	logic [kstg_pkg::PHASE_W-1:0]          phase;
	logic [kstg_pkg::IDX_W-1:0]            idx;
	logic [kstg_pkg::IDX_W-1:0]            nidx;
	logic [kstg_pkg::PHASE_W:0]            phase_sum;
	logic [kstg_pkg::PHASE_W-1:0]          phase_next;
	logic signed [kstg_pkg::SAMPLE_W-1:0]  rom_a;
	logic signed [kstg_pkg::SAMPLE_W-1:0]  rom_b;

	logic signed [kstg_pkg::SAMPLE_W-1:0]    a_s2;
	logic signed [kstg_pkg::DIFF_W-1:0]      diff_s2;
	logic [kstg_pkg::FRACTION_BITS-1:0]      frac_s2;
	logic signed [kstg_pkg::PROD_W-1:0]      mac;
	logic signed [kstg_pkg::P_W-1:0]         p_s3;
	logic [kstg_pkg::P_W-1:0]                p_abs;
	logic [kstg_pkg::MV_W-1:0]               mv;
	logic                                    neg_s4;
	logic [kstg_pkg::Y_W-1:0]                y_s4;
	logic [kstg_pkg::VP_W-1:0]               vp;
	logic [kstg_pkg::SAMPLE_W-1:0]           q0_s5;
	logic [kstg_pkg::Y_W-1:0]                rem;
	logic [kstg_pkg::SAMPLE_W-1:0]           q_fix;
	logic signed [kstg_pkg::SAMPLE_W-1:0]    result;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign sample    = sample_q;
	assign ram_addr  = '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= kstg_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		ready    = 1'b0;
		out_load = 1'b0;
		ram_we   = 1'b0;
		case (state_q)
			kstg_pkg::ST_IDLE: begin
				ready = 1'b1;
				if (take)
					state_d = kstg_pkg::ST_LOOK;
			end
			kstg_pkg::ST_LOOK: begin
				ram_we  = 1'b1;
				state_d = kstg_pkg::ST_MAC;
			end
			kstg_pkg::ST_MAC:   state_d = kstg_pkg::ST_SCALE;
			kstg_pkg::ST_SCALE: state_d = kstg_pkg::ST_RECIP;
			kstg_pkg::ST_RECIP: state_d = kstg_pkg::ST_FIX;
			kstg_pkg::ST_FIX: begin
				if (out_free) begin
					ready    = 1'b1;
					out_load = 1'b1;
					state_d  = take ? kstg_pkg::ST_LOOK : kstg_pkg::ST_IDLE;
				end
			end
			default: state_d = kstg_pkg::ST_IDLE;
		endcase
	end

	kstg_ram #(
		.WIDTH(kstg_pkg::PHASE_W),
		.DEPTH(kstg_pkg::PHASE_DEPTH),
		.AW   (kstg_pkg::PHASE_AW)
	) u_phase_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_addr),
		.wdata(ram_wdata),
		.re   (take),
		.raddr(ram_addr),
		.rdata(ram_rdata)
	);

	// The phase entry reads as zero until its first write after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_vld_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ram_we)
				phase_vld_q <= 1'b1;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		phase     = phase_vld_q ? ram_rdata : '0;
		idx       = phase[kstg_pkg::PHASE_W-1:kstg_pkg::FRACTION_BITS];
		nidx      = idx + 1'b1;
		rom_a     = kstg_pkg::SINE_ROM[idx];
		rom_b     = kstg_pkg::SINE_ROM[nidx];
		phase_sum = (kstg_pkg::PHASE_W + 1)'(phase) + (kstg_pkg::PHASE_W + 1)'(cfg.inc);
		if (phase_sum >= (kstg_pkg::PHASE_W + 1)'(kstg_pkg::MODULUS))
			phase_next = kstg_pkg::PHASE_W'(phase_sum
				- (kstg_pkg::PHASE_W + 1)'(kstg_pkg::MODULUS));
		else
			phase_next = kstg_pkg::PHASE_W'(phase_sum);
		ram_wdata = key_s1 ? phase_next : '0;
	end

	// A released key zeroes both interpolation terms, so the silent sample
	// runs through the same steps as a tone sample.
	always_comb begin
		mac = (kstg_pkg::PROD_W'(a_s2) <<< kstg_pkg::FRACTION_BITS)
			+ kstg_pkg::PROD_W'(diff_s2) * kstg_pkg::PROD_W'($signed({1'b0, frac_s2}));
		p_abs = p_s3[kstg_pkg::P_W-1] ? kstg_pkg::P_W'(-p_s3) : kstg_pkg::P_W'(p_s3);
		mv    = kstg_pkg::MV_W'(p_abs[kstg_pkg::MAG_W-1:0]) * kstg_pkg::MV_W'(cfg.vol);
		vp    = kstg_pkg::VP_W'(y_s4) * kstg_pkg::VP_W'(kstg_pkg::VRCP);
		rem   = y_s4 - kstg_pkg::Y_W'(kstg_pkg::Y_W'(q0_s5) * kstg_pkg::Y_W'(kstg_pkg::VOL_MAX));
		q_fix = q0_s5 + kstg_pkg::SAMPLE_W'(rem >= kstg_pkg::Y_W'(kstg_pkg::VOL_MAX));
		result = neg_s4 ? -$signed(q_fix) : $signed(q_fix);
	end

	always_ff @(posedge clk) begin
		if (take)
			key_s1 <= key_on;
		if (state_q == kstg_pkg::ST_LOOK) begin
			a_s2    <= key_s1 ? rom_a : '0;
			diff_s2 <= key_s1 ? (kstg_pkg::DIFF_W'(rom_b) - kstg_pkg::DIFF_W'(rom_a)) : '0;
			frac_s2 <= phase[kstg_pkg::FRACTION_BITS-1:0];
		end
		if (state_q == kstg_pkg::ST_MAC)
			p_s3 <= kstg_pkg::P_W'(mac);
		if (state_q == kstg_pkg::ST_SCALE) begin
			neg_s4 <= p_s3[kstg_pkg::P_W-1];
			y_s4   <= kstg_pkg::Y_W'(mv >> kstg_pkg::FRACTION_BITS);
		end
		if (state_q == kstg_pkg::ST_RECIP)
			q0_s5 <= kstg_pkg::SAMPLE_W'(vp >> kstg_pkg::VS);
		if (out_load)
			sample_q <= result;
	end

endmodule

### design/keyed_sine_tone_generator_top.sv
// Top level of the keyed sine tone generator.
//
//  channel | signals                               | beat
//  --------+---------------------------------------+----------------------------
//  input   | in_valid, in_stall, key_on            | one sample tick, key state
//  output  | out_valid, out_stall, sample          | one signed 16-bit sample
//  config  | psel, penable, pwrite, paddr, pwdata, | frequency at 0, volume at 4
//          | prdata, pready                        |
//
// When beats arrive back to back, each input beat passes through the phase
// memory read, table lookup and phase write-back, the interpolation multiply,
// the volume multiply and the reciprocal multiply for the divide by 100, with
// the final correction overlapping the next beat's phase read.
// After reset, and after a frequency write, in_stall stays high while the
// phase increment is derived again.
// A finished sample waits in the output register; a stalled output holds the
// datapath at its last step until the register frees.
module keyed_sine_tone_generator_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [kstg_pkg::ADDR_W-1:0]          paddr,
	input  logic [kstg_pkg::DATA_W-1:0]          pwdata,
	output logic [kstg_pkg::DATA_W-1:0]          prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 key_on,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [kstg_pkg::SAMPLE_W-1:0] sample
);

	kstg_pkg::cfg_t cfg;
	logic           core_ready;
	logic           take;

	assign in_stall = !core_ready || cfg.busy;
	assign take     = in_valid && !in_stall;

	kstg_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	kstg_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.take     (take),
		.key_on   (key_on),
		.ready    (core_ready),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample   (sample)
	);

endmodule
